// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-implication and next-cycle-implication checks with async reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants and types of the frame peak AGC.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FRAME_LEN  = 160;
	localparam int HIST_LEN   = 25;

	localparam int SAMPLE_W   = 24;
	localparam int PEAK_W     = 23;
	localparam int GAIN_W     = 22;
	localparam int TARGET_W   = 15;
	localparam int REL_W      = 16;
	localparam int OUT_W      = 16;
	localparam int PROD_W     = SAMPLE_W + GAIN_W;
	localparam int LIM_W      = GAIN_W + REL_W;

	localparam int CNT_W      = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
	localparam int SLOT_W     = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
	localparam int DIV_CNT_W  = $clog2(GAIN_W);

	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = GAIN_W;

	localparam logic [PEAK_W-1:0]   PEAK_MAX   = '1;
	localparam logic [GAIN_W-1:0]   GAIN_MAX   = '1;
	localparam logic [OUT_W-2:0]    OUT_MAX    = '1;

	localparam logic [TARGET_W-1:0] TARGET_RST = 15'd32767;
	localparam logic [GAIN_W-1:0]   CEIL_RST   = 22'd3276800;
	localparam logic [GAIN_W-1:0]   GAIN_RST   = 22'd1638400;
	localparam logic [REL_W-1:0]    REL_RST    = 16'd3277;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd3;

	typedef struct packed {
		logic                emit;
		logic                last;
		logic                frame_end;
		logic [SAMPLE_W-1:0] sample;
		logic [PEAK_W-1:0]   peak;
	} fpa_job_t;

endpackage

// ===== rtl/fpa_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_fifo
// Short job queue between the sample front end and the gain back end.
// ----------------------------------------------------------------------------
module fpa_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  fpa_pkg::fpa_job_t            wr_job,
	input  logic                         pop,
	output fpa_pkg::fpa_job_t            rd_job,
	output logic [fpa_pkg::Q_CNT_W-1:0]  count
);

	fpa_pkg::fpa_job_t               mem_q [fpa_pkg::Q_DEPTH];
	logic [fpa_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [fpa_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [fpa_pkg::Q_CNT_W-1:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + fpa_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fpa_pkg::Q_PTR_W'(1);
			end
			count_q <= count_q + fpa_pkg::Q_CNT_W'(push) - fpa_pkg::Q_CNT_W'(pop);
		end
	end

	assign rd_job = mem_q[rd_ptr_q];
	assign count  = count_q;

endmodule

// ===== rtl/fpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// Takes samples, keeps the frame store and frame peak, queues output jobs.
// ----------------------------------------------------------------------------
module fpa_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [fpa_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [fpa_pkg::Q_CNT_W-1:0]   q_count,
	output logic                          push,
	output fpa_pkg::fpa_job_t             job
);

	localparam int SW = fpa_pkg::Q_CNT_W + 1;

	logic [fpa_pkg::SAMPLE_W-1:0] frame_mem [fpa_pkg::FRAME_LEN];
	logic [fpa_pkg::SAMPLE_W-1:0] rd_s1;
	logic                         valid_s1;
	logic                         emit_s1;
	logic                         last_s1;
	logic [fpa_pkg::PEAK_W-1:0]   peak_s1;
	logic [fpa_pkg::CNT_W-1:0]    count_q;
	logic [fpa_pkg::PEAK_W-1:0]   peak_q;
	logic                         primed_q;

	logic                         accept;
	logic                         at_end;
	logic [fpa_pkg::SAMPLE_W-1:0] neg;
	logic [fpa_pkg::PEAK_W-1:0]   mag;
	logic [fpa_pkg::PEAK_W-1:0]   peak_new;

	// room for the job in flight plus this one
	assign in_stall = (SW'(q_count) + SW'(valid_s1)) >= SW'(fpa_pkg::Q_DEPTH);
	assign accept   = in_valid && !in_stall;
	assign at_end   = count_q == fpa_pkg::CNT_W'(fpa_pkg::FRAME_LEN - 1);

	always_comb begin
		neg = ~sample_in + fpa_pkg::SAMPLE_W'(1);
		if (sample_in[fpa_pkg::SAMPLE_W-1]) begin
			mag = neg[fpa_pkg::SAMPLE_W-1] ? fpa_pkg::PEAK_MAX : neg[fpa_pkg::PEAK_W-1:0];
		end else begin
			mag = sample_in[fpa_pkg::PEAK_W-1:0];
		end
		peak_new = (mag > peak_q) ? mag : peak_q;
	end

	// read-first: the old sample leaves before the new one lands
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1              <= frame_mem[count_q];
			frame_mem[count_q] <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
			peak_s1  <= '0;
			count_q  <= '0;
			peak_q   <= '0;
			primed_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				emit_s1 <= primed_q;
				last_s1 <= at_end;
				peak_s1 <= peak_new;
				if (at_end) begin
					count_q  <= '0;
					peak_q   <= '0;
					primed_q <= 1'b1;
				end else begin
					count_q <= count_q + fpa_pkg::CNT_W'(1);
					peak_q  <= peak_new;
				end
			end
		end
	end

	assign push          = valid_s1 && (emit_s1 || last_s1);
	assign job.emit      = emit_s1;
	assign job.last      = last_s1;
	assign job.frame_end = last_s1;
	assign job.sample    = rd_s1;
	assign job.peak      = peak_s1;

endmodule

// ===== rtl/fpa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_back
// Scales queued samples by the gain and runs the frame-end gain update.
// ----------------------------------------------------------------------------
module fpa_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [fpa_pkg::Q_CNT_W-1:0]      q_count,
	input  fpa_pkg::fpa_job_t                head,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [fpa_pkg::OUT_W-1:0] sample_out,
	output logic                             frame_last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_HWR  = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_DIVS = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_UPD  = 3'd7;

	localparam int SW = fpa_pkg::SAMPLE_W;
	localparam int PW = fpa_pkg::PEAK_W;
	localparam int GW = fpa_pkg::GAIN_W;

	logic [2:0]                        state_q;
	logic [GW-1:0]                     gain_q;
	logic                              locked_q;
	logic [fpa_pkg::TARGET_W-1:0]      target_q;
	logic [GW-1:0]                     ceil_q;
	logic [fpa_pkg::REL_W-1:0]         rel_q;
	logic [PW-1:0]                     hist_q [fpa_pkg::HIST_LEN];
	logic [fpa_pkg::SLOT_W-1:0]        slot_q;
	logic [fpa_pkg::SLOT_W-1:0]        idx_q;
	logic [PW-1:0]                     max_q;
	logic [fpa_pkg::LIM_W-1:0]         lim_prod_q;
	logic [PW-1:0]                     rem_q;
	logic [GW-1:0]                     factor_q;
	logic [fpa_pkg::DIV_CNT_W-1:0]     step_q;
	logic                              neg_q;
	logic [SW-1:0]                     mag_q;
	logic                              last_q;
	logic                              fe_q;
	logic [PW-1:0]                     peak_q;
	logic [fpa_pkg::PROD_W-1:0]        prod_q;
	logic                              out_valid_q;
	logic [fpa_pkg::OUT_W-1:0]         out_data_q;
	logic                              out_last_q;

	logic                              out_free;
	logic [GW-1:0]                     q_int;
	logic [SW-1:0]                     r_frac;
	logic                              round_up;
	logic [GW:0]                       q_rnd;
	logic [fpa_pkg::OUT_W-2:0]         q_sat;
	logic [fpa_pkg::OUT_W-1:0]         scaled;
	logic [PW:0]                       rem2;
	logic                              div_ge;
	logic [PW-1:0]                     tgt4;
	logic [GW-1:0]                     limit;
	logic [GW-1:0]                     capped;
	logic [GW-1:0]                     new_gain;

	assign pop      = (state_q == ST_IDLE) && (q_count != '0);
	assign out_free = !out_valid_q || !out_stall;

	// round half to even on the magnitude, then saturate and sign
	always_comb begin
		q_int    = prod_q[fpa_pkg::PROD_W-1:SW];
		r_frac   = prod_q[SW-1:0];
		round_up = (r_frac > {1'b1, {(SW-1){1'b0}}}) ||
			((r_frac == {1'b1, {(SW-1){1'b0}}}) && q_int[0]);
		q_rnd    = (GW+1)'(q_int) + (GW+1)'(round_up);
		q_sat    = (q_rnd > (GW+1)'(fpa_pkg::OUT_MAX)) ? fpa_pkg::OUT_MAX
			: q_rnd[fpa_pkg::OUT_W-2:0];
		scaled   = neg_q ? (~{1'b0, q_sat} + fpa_pkg::OUT_W'(1)) : {1'b0, q_sat};
	end

	always_comb begin
		rem2   = {rem_q, 1'b0};
		div_ge = rem2 >= {1'b0, max_q};
		tgt4   = PW'({target_q, 2'b00});
	end

	always_comb begin
		limit  = lim_prod_q[fpa_pkg::LIM_W-1:fpa_pkg::REL_W];
		capped = (factor_q > ceil_q) ? ceil_q : factor_q;
		if (factor_q < gain_q) begin
			new_gain = factor_q;
		end else if (capped < gain_q) begin
			new_gain = capped;
		end else if ((capped - gain_q) > limit) begin
			new_gain = gain_q + limit;
		end else begin
			new_gain = capped;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					neg_q  <= head.sample[SW-1];
					mag_q  <= head.sample[SW-1] ? (~head.sample + SW'(1)) : head.sample;
					last_q <= head.last;
					fe_q   <= head.frame_end;
					peak_q <= head.peak;
				end
			end
			ST_MUL: begin
				prod_q <= fpa_pkg::PROD_W'(mag_q) * fpa_pkg::PROD_W'(gain_q);
			end
			ST_RND: begin
				if (out_free) begin
					out_data_q <= scaled;
					out_last_q <= last_q;
				end
			end
			ST_HWR: begin
				lim_prod_q <= fpa_pkg::LIM_W'(gain_q) * fpa_pkg::LIM_W'(rel_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gain_q      <= fpa_pkg::GAIN_RST;
			locked_q    <= 1'b0;
			target_q    <= fpa_pkg::TARGET_RST;
			ceil_q      <= fpa_pkg::CEIL_RST;
			rel_q       <= fpa_pkg::REL_RST;
			for (int i = 0; i < fpa_pkg::HIST_LEN; i++) begin
				hist_q[i] <= '0;
			end
			slot_q      <= '0;
			idx_q       <= '0;
			max_q       <= '0;
			rem_q       <= '0;
			factor_q    <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_RND)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.emit) begin
							state_q <= ST_MUL;
						end else if (head.frame_end) begin
							state_q <= ST_HWR;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= fe_q ? ST_HWR : ST_IDLE;
					end
				end
				ST_HWR: begin
					hist_q[slot_q] <= peak_q;
					slot_q <= (slot_q == fpa_pkg::SLOT_W'(fpa_pkg::HIST_LEN - 1)) ? '0
						: slot_q + fpa_pkg::SLOT_W'(1);
					idx_q   <= '0;
					max_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hist_q[idx_q] > max_q) begin
						max_q <= hist_q[idx_q];
					end
					if (idx_q == fpa_pkg::SLOT_W'(fpa_pkg::HIST_LEN - 1)) begin
						state_q <= ST_DIVS;
					end else begin
						idx_q <= idx_q + fpa_pkg::SLOT_W'(1);
					end
				end
				ST_DIVS: begin
					if (max_q == '0) begin
						factor_q <= ceil_q;
						state_q  <= ST_UPD;
					end else if (tgt4 >= max_q) begin
						// quotient would not fit the gain width
						factor_q <= fpa_pkg::GAIN_MAX;
						state_q  <= ST_UPD;
					end else begin
						rem_q    <= tgt4;
						factor_q <= '0;
						step_q   <= fpa_pkg::DIV_CNT_W'(GW - 1);
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q    <= div_ge ? PW'(rem2 - {1'b0, max_q}) : PW'(rem2);
					factor_q <= {factor_q[GW-2:0], div_ge};
					step_q   <= step_q - fpa_pkg::DIV_CNT_W'(1);
					if (step_q == '0) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					gain_q   <= new_gain;
					locked_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					fpa_pkg::REG_TARGET: begin
						target_q <= cfg_data[fpa_pkg::TARGET_W-1:0];
					end
					fpa_pkg::REG_CEILING: begin
						ceil_q <= cfg_data;
					end
					fpa_pkg::REG_INIT_GAIN: begin
						if (!locked_q) begin
							gain_q <= cfg_data;
						end
					end
					fpa_pkg::REG_RELEASE: begin
						rel_q <= cfg_data[fpa_pkg::REL_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;
	assign frame_last = out_last_q;

endmodule

// ===== rtl/frame_peak_agc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_peak_agc
// Frame-based peak-tracking AGC: one frame of latency, gain set per frame.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  input     in   in_valid / in_stall   sample_in
//  output    out  out_valid / out_stall sample_out, frame_last
//  config    in   cfg_we                cfg_index, cfg_data
//
// Input side takes a transaction per cycle into a 4-entry job queue while it
// has room; output side pops, multiplies and rounds each sample in turn.
// A frame end holds the output side for history write, scan, divider setup,
// 22-step divider and gain update; the input stalls once the queue fills.
// Reset is asynchronous: gain loads 25.0, history clears.
// in_stall rises when the queue cannot take another transaction.
`include "assert_macros.svh"

module frame_peak_agc (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fpa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fpa_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [fpa_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fpa_pkg::OUT_W-1:0]     sample_out,
	output logic                                 frame_last
);

	logic                          push;
	logic                          pop;
	fpa_pkg::fpa_job_t             wr_job;
	fpa_pkg::fpa_job_t             head;
	logic [fpa_pkg::Q_CNT_W-1:0]   q_count;
	logic                          q_full;

	assign q_full = q_count == fpa_pkg::Q_CNT_W'(fpa_pkg::Q_DEPTH);

	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.q_count   (q_count),
		.push      (push),
		.job       (wr_job)
	);

	fpa_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (head),
		.count  (q_count)
	);

	fpa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_count    (q_count),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.frame_last (frame_last)
	);

	`FPA_ASSERT_NOW(a_push_room, clk, arst_n, push, !q_full, "job queue overflow")
	`FPA_ASSERT_NOW(a_pop_data, clk, arst_n, pop, q_count != '0, "pop from empty job queue")
	`FPA_ASSERT_NOW(a_full_stall, clk, arst_n, q_full, in_stall, "full queue not stalling")
	`FPA_ASSERT_NEXT(a_fe_busy, clk, arst_n, pop && head.frame_end, !pop, "pop in frame end")

endmodule

// ===== bench/frame_peak_agc_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_peak_agc_test
// Self-checking bench for the frame peak AGC. A behavioral copy of the gain
// loop tracks the frame buffer, peak history and gain, and predicts every
// scaled PCM sample. Directed tests cover the first frame, a zero peak,
// full-scale input, a ceiling under the present gain and a zero target.
// Random traffic follows under four idle and stall profiles.
// ----------------------------------------------------------------------------
module frame_peak_agc_test;

	typedef struct packed {
		logic signed [fpa_pkg::OUT_W-1:0] pcm;
		logic                             last;
	} pcm_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_we = 1'b0;
	logic [fpa_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
	logic [fpa_pkg::CFG_DATA_W-1:0]       cfg_data = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic signed [fpa_pkg::SAMPLE_W-1:0]  sample_in = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic signed [fpa_pkg::OUT_W-1:0]     sample_out;
	logic                                 frame_last;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int mismatches = 0;

	pcm_t pcm_expected[$];

	// gain loop state
	logic [fpa_pkg::SAMPLE_W-1:0]  frame_mem [fpa_pkg::FRAME_LEN];
	logic [fpa_pkg::PEAK_W-1:0]    peak_ring [fpa_pkg::HIST_LEN];
	int                            ring_pos;
	int                            frame_pos;
	logic [fpa_pkg::PEAK_W-1:0]    frame_peak;
	logic [fpa_pkg::GAIN_W-1:0]    agc_gain;
	bit                            primed_q;
	logic [fpa_pkg::TARGET_W-1:0]  cfg_target;
	logic [fpa_pkg::GAIN_W-1:0]    cfg_ceiling;
	logic [fpa_pkg::GAIN_W-1:0]    cfg_init;
	logic [fpa_pkg::REL_W-1:0]     cfg_release;

	frame_peak_agc u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.frame_last (frame_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [fpa_pkg::OUT_W-1:0] apply_gain(
			logic [fpa_pkg::SAMPLE_W-1:0] s);
		logic [fpa_pkg::SAMPLE_W-1:0] mag;
		logic [fpa_pkg::PROD_W-1:0]   prod;
		logic [fpa_pkg::GAIN_W:0]     q;
		mag = s[fpa_pkg::SAMPLE_W-1] ? -s : s;
		prod = fpa_pkg::PROD_W'(mag) * fpa_pkg::PROD_W'(agc_gain);
		q = (fpa_pkg::GAIN_W+1)'(prod[fpa_pkg::PROD_W-1:fpa_pkg::SAMPLE_W]);
		if (prod[23:0] > 24'h800000 || (prod[23:0] == 24'h800000 && q[0]))
			q = q + (fpa_pkg::GAIN_W+1)'(1);
		if (q > (fpa_pkg::GAIN_W+1)'(fpa_pkg::OUT_MAX))
			q = (fpa_pkg::GAIN_W+1)'(fpa_pkg::OUT_MAX);
		return s[fpa_pkg::SAMPLE_W-1] ? -q[fpa_pkg::OUT_W-1:0] : q[fpa_pkg::OUT_W-1:0];
	endfunction

	task automatic close_frame();
		logic [fpa_pkg::PEAK_W-1:0] top;
		logic [63:0]                num;
		logic [63:0]                quo;
		logic [fpa_pkg::GAIN_W-1:0] want;
		logic [fpa_pkg::LIM_W-1:0]  rise;
		logic [fpa_pkg::GAIN_W-1:0] limit;
		peak_ring[ring_pos] = frame_peak;
		ring_pos = (ring_pos + 1 == fpa_pkg::HIST_LEN) ? 0 : ring_pos + 1;
		top = '0;
		for (int i = 0; i < fpa_pkg::HIST_LEN; i++)
			if (peak_ring[i] > top)
				top = peak_ring[i];
		if (top != '0) begin
			num = 64'(cfg_target) << 24;
			quo = num / 64'(top);
			want = (quo > 64'(fpa_pkg::GAIN_MAX)) ? fpa_pkg::GAIN_MAX
				: quo[fpa_pkg::GAIN_W-1:0];
		end else begin
			want = cfg_ceiling;
		end
		if (want < agc_gain) begin
			agc_gain = want;
		end else begin
			if (want > cfg_ceiling)
				want = cfg_ceiling;
			if (want < agc_gain) begin
				agc_gain = want;
			end else begin
				rise = fpa_pkg::LIM_W'(agc_gain) * fpa_pkg::LIM_W'(cfg_release);
				limit = rise[fpa_pkg::LIM_W-1:fpa_pkg::REL_W];
				if (want - agc_gain > limit)
					want = agc_gain + limit;
				agc_gain = want;
			end
		end
		frame_peak = '0;
		frame_pos = 0;
		primed_q = 1'b1;
	endtask

	task automatic predict_pcm(logic [fpa_pkg::SAMPLE_W-1:0] s);
		pcm_t                         res;
		logic [fpa_pkg::SAMPLE_W-1:0] mag;
		logic [fpa_pkg::PEAK_W-1:0]   pk;
		if (primed_q) begin
			res.pcm = apply_gain(frame_mem[frame_pos]);
			res.last = (frame_pos == fpa_pkg::FRAME_LEN - 1);
			pcm_expected.push_back(res);
		end
		frame_mem[frame_pos] = s;
		mag = s[fpa_pkg::SAMPLE_W-1] ? -s : s;
		pk = (s == 24'h800000) ? fpa_pkg::PEAK_MAX : mag[fpa_pkg::PEAK_W-1:0];
		if (pk > frame_peak)
			frame_peak = pk;
		frame_pos++;
		if (frame_pos == fpa_pkg::FRAME_LEN)
			close_frame();
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_sample(logic [fpa_pkg::SAMPLE_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= v;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		predict_pcm(v);
		@(negedge clk);
	endtask

	task automatic send_noise(int count, int amp);
		logic [fpa_pkg::SAMPLE_W-1:0] v;
		for (int n = 0; n < count; n++) begin
			v = fpa_pkg::SAMPLE_W'($urandom_range(2 * amp) - amp);
			send_sample(v);
		end
	endtask

	task automatic program_agc(logic [fpa_pkg::GAIN_W-1:0] tgt,
			logic [fpa_pkg::GAIN_W-1:0] ceil, logic [fpa_pkg::GAIN_W-1:0] init,
			logic [fpa_pkg::GAIN_W-1:0] rel);
		logic [fpa_pkg::CFG_DATA_W-1:0] value [4];
		logic [fpa_pkg::CFG_IDX_W-1:0]  reg_idx;
		value[fpa_pkg::REG_TARGET] = tgt;
		value[fpa_pkg::REG_CEILING] = ceil;
		value[fpa_pkg::REG_INIT_GAIN] = init;
		value[fpa_pkg::REG_RELEASE] = rel;
		for (int i = 0; i < 4; i++) begin
			reg_idx = fpa_pkg::CFG_IDX_W'(i);
			cfg_we <= 1'b1;
			cfg_index <= reg_idx;
			cfg_data <= value[i];
			@(posedge clk);
			case (reg_idx)
				fpa_pkg::REG_TARGET: cfg_target = value[i][fpa_pkg::TARGET_W-1:0];
				fpa_pkg::REG_CEILING: cfg_ceiling = value[i];
				fpa_pkg::REG_INIT_GAIN: begin
					cfg_init = value[i];
					if (!primed_q)
						agc_gain = cfg_init;
				end
				fpa_pkg::REG_RELEASE: cfg_release = value[i][fpa_pkg::REL_W-1:0];
				default: begin
				end
			endcase
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// wait out every pending sample plus the frame-end gain update
	task automatic drain_and_wait();
		in_valid <= 1'b0;
		while (pcm_expected.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_quiet_start();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		program_agc(22'd20000, fpa_pkg::CEIL_RST, 22'd65536, 22'd65535);
		send_noise(2 * fpa_pkg::FRAME_LEN, 0);
	endtask

	task automatic test_peak_tracking();
		src_idle_pct = 67;
		sink_stall_pct = 0;
		send_noise(fpa_pkg::FRAME_LEN, 'hFFFF);
		send_noise(fpa_pkg::FRAME_LEN, 'h3FFF);
		send_noise(fpa_pkg::FRAME_LEN, 'hFF);
	endtask

	task automatic test_ceiling_drop();
		drain_and_wait();
		src_idle_pct = 0;
		sink_stall_pct = 67;
		program_agc(22'd32767, 22'd65536, fpa_pkg::GAIN_MAX, 22'd0);
		send_noise(fpa_pkg::FRAME_LEN, 'hFFF);
	endtask

	task automatic test_sample_extremes();
		drain_and_wait();
		src_idle_pct = 20;
		sink_stall_pct = 20;
		program_agc(22'd32767, fpa_pkg::GAIN_MAX, 22'd65536, 22'd65535);
		send_sample(24'h000000);
		send_sample(24'h000001);
		send_sample(24'hFFFFFF);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h800001);
		send_sample(24'h000080);
		send_sample(24'hFFFF80);
		send_sample(24'h400000);
		send_sample(24'hC00000);
		send_sample(24'h555555);
		send_sample(24'hAAAAAA);
		send_sample(24'h7FFF00);
		send_sample(24'h0000FF);
		send_sample(24'h800100);
		send_sample(24'h010000);
		while (frame_pos != 0)
			send_sample('0);
		send_noise(fpa_pkg::FRAME_LEN, 'h7F);
	endtask

	task automatic test_random_traffic(int phase);
		int sent;
		int chunk;
		int amp;
		drain_and_wait();
		case (phase)
			0: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
				program_agc(fpa_pkg::GAIN_W'($urandom_range(32767, 1)),
					fpa_pkg::GAIN_W'($urandom_range(fpa_pkg::GAIN_MAX, 65536)),
					fpa_pkg::GAIN_W'($urandom_range(fpa_pkg::GAIN_MAX, 65536)),
					fpa_pkg::GAIN_W'($urandom_range(65535)));
			end
			1: begin
				src_idle_pct = 67;
				sink_stall_pct = 0;
				program_agc(fpa_pkg::GAIN_W'(22'h3F8000 | $urandom_range(32767, 1)),
					fpa_pkg::GAIN_W'($urandom_range(fpa_pkg::GAIN_MAX, 32768)),
					fpa_pkg::GAIN_W'($urandom_range(fpa_pkg::GAIN_MAX)),
					fpa_pkg::GAIN_W'(22'h3F0000 | $urandom_range(65535)));
			end
			2: begin
				src_idle_pct = 0;
				sink_stall_pct = 67;
				program_agc(22'd32767, fpa_pkg::GAIN_MAX, fpa_pkg::GAIN_MAX, 22'd65535);
			end
			default: begin
				src_idle_pct = 20;
				sink_stall_pct = 20;
				program_agc(22'd1, 22'd65536, 22'd65536, 22'd0);
			end
		endcase
		sent = 0;
		while (sent < 90) begin
			if ($urandom_range(3) == 0) begin
				send_sample($urandom_range(1) ? 24'h800000 : 24'h7FFFFF);
				sent++;
			end
			case ($urandom_range(4))
				0: amp = 0;
				1: amp = 'hFF;
				2: amp = 'h7FFF;
				3: amp = 'h1FFFFF;
				default: amp = 'h7FFFFF;
			endcase
			chunk = fpa_pkg::FRAME_LEN - frame_pos;
			if (chunk > 90 - sent)
				chunk = 90 - sent;
			send_noise(chunk, amp);
			sent += chunk;
		end
	endtask

	// gain collapses to zero here and cannot recover, so this runs last
	task automatic test_zero_target();
		drain_and_wait();
		src_idle_pct = 67;
		sink_stall_pct = 67;
		program_agc(22'h3F8000, fpa_pkg::GAIN_MAX, 22'd65536, 22'd32768);
		send_noise(fpa_pkg::FRAME_LEN - frame_pos, 'hFFFF);
		send_noise(fpa_pkg::FRAME_LEN, 'hFFFF);
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < sink_stall_pct);

	always @(posedge clk) begin : check_pcm
		pcm_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pcm_expected.size() == 0) begin
				mismatches++;
				$error("unexpected transaction: sample_out %0d frame_last %0d",
					sample_out, frame_last);
			end else begin
				want = pcm_expected.pop_front();
				if (sample_out !== want.pcm) begin
					mismatches++;
					$error("sample_out: expected %0d, got %0d", $signed(want.pcm), sample_out);
				end
				if (frame_last !== want.last) begin
					mismatches++;
					$error("frame_last: expected %0d, got %0d", want.last, frame_last);
				end
			end
		end
	end

	initial begin
		cfg_target = fpa_pkg::TARGET_RST;
		cfg_ceiling = fpa_pkg::CEIL_RST;
		cfg_init = fpa_pkg::GAIN_RST;
		cfg_release = fpa_pkg::REL_RST;
		agc_gain = fpa_pkg::GAIN_RST;
		for (int i = 0; i < fpa_pkg::HIST_LEN; i++)
			peak_ring[i] = '0;
		ring_pos = 0;
		frame_pos = 0;
		frame_peak = '0;
		primed_q = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_quiet_start();
		test_peak_tracking();
		test_ceiling_drop();
		test_sample_extremes();
		for (int p = 0; p < 4; p++)
			test_random_traffic(p);
		test_zero_target();
		drain_and_wait();

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$error("run did not finish in time");
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== frame_peak_agc.f =====
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fpa_fifo.sv
rtl/fpa_front.sv
rtl/fpa_back.sv
rtl/frame_peak_agc.sv
bench/frame_peak_agc_test.sv
